/* hw/rtl/three_rotor_enigma_cipher_defines.svh */
// ----------------------------------------------------------------------------
// Enigma cipher assertion macros
// Concurrent assertion wrappers shared by the cipher's checker.
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_ENIGMA_CIPHER_DEFINES_SVH
`define THREE_ROTOR_ENIGMA_CIPHER_DEFINES_SVH

// Property checked only while out of reset.
`define ERC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define ERC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/erc_pkg.sv */
// ----------------------------------------------------------------------------
// Enigma cipher package
// Rotor wirings, inverse wirings, notch positions and modulo-26 helpers.
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int unsigned ALPHA = 26;

  localparam logic [4:0] RIGHT_NOTCH  = 5'd7;
  localparam logic [4:0] MIDDLE_NOTCH = 5'd19;
  localparam logic [4:0] RIGHT_RESET  = 5'd25;

  typedef enum logic [1:0] {
    CFG_START_RIGHT  = 2'd0,
    CFG_START_MIDDLE = 2'd1,
    CFG_START_LEFT   = 2'd2
  } erc_cfg_e;

  typedef struct packed {
    logic [4:0] left;
    logic [4:0] middle;
    logic [4:0] right;
  } erc_rotor_t;

  localparam logic [4:0] WIRE_RIGHT [ALPHA] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14
  };
  localparam logic [4:0] WIRE_MIDDLE [ALPHA] = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4
  };
  localparam logic [4:0] WIRE_LEFT [ALPHA] = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9
  };
  localparam logic [4:0] WIRE_REFLECT [ALPHA] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19
  };

  // Inverse wirings: entry c holds the contact index that carries letter c
  localparam logic [4:0] INV_RIGHT [ALPHA] = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12
  };
  localparam logic [4:0] INV_MIDDLE [ALPHA] = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18
  };
  localparam logic [4:0] INV_LEFT [ALPHA] = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9
  };

  // (a + b) mod 26 for a, b below 32 with a + b below 52
  function automatic logic [4:0] add_mod26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(ALPHA)) begin
      s = s - 6'(ALPHA);
    end
    return s[4:0];
  endfunction

  // (a - b) mod 26 for a, b in 0..25
  function automatic logic [4:0] sub_mod26(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (s[5]) begin
      s = s + 6'(ALPHA);
    end
    return s[4:0];
  endfunction

endpackage

/* hw/rtl/three_rotor_enigma_cipher.sv */
// Path: an input transaction is held in the input register, then its enciphered letter
// in the result register until the result transaction.
// Throughput: one letter per cycle unless the output stalls; rotor stepping runs on the
// input side, and the substitution path is one combinational pass between the registers.
// Reset: rotors go to right 25, middle 0, left 0; start registers to the same;
// input and result registers empty.
// ----------------------------------------------------------------------------
// Three-rotor Enigma cipher
// Steps the rotors per letter and enciphers it in a single registered pass.
// ----------------------------------------------------------------------------
module three_rotor_enigma_cipher
  import erc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [4:0] letter_in, [7:5] zero
  input  logic       s_axis_tuser,   // [0] restart
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [4:0] letter_out, [7:5] zero
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] start_right_q, start_middle_q, start_left_q;
  erc_rotor_t rotor_q, rotor_d, base;

  logic       st1_v_q, out_v_q;
  logic [4:0] st1_letter_q, out_letter_q;
  erc_rotor_t st1_rotor_q;
  logic [4:0] out_letter_d;
  logic [4:0] fr, fm, fl, rf, bl, bm;

  logic s_accept, out_rdy;

  assign out_rdy       = !out_v_q || m_axis_tready;
  assign s_axis_tready = !st1_v_q || out_rdy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Odometer stepping; left moves only when the middle steps onto its notch
  always_comb begin
    if (s_axis_tuser) begin
      base.right  = add_mod26(start_right_q, 5'd0);
      base.middle = add_mod26(start_middle_q, 5'd0);
      base.left   = add_mod26(start_left_q, 5'd0);
    end else begin
      base = rotor_q;
    end
    rotor_d       = base;
    rotor_d.right = add_mod26(base.right, 5'd1);
    if (rotor_d.right == RIGHT_NOTCH) begin
      rotor_d.middle = add_mod26(base.middle, 5'd1);
      if (rotor_d.middle == MIDDLE_NOTCH) begin
        rotor_d.left = add_mod26(base.left, 5'd1);
      end
    end
  end

  // Forward through the rotors and the reflector, then back through the inverse wirings
  always_comb begin
    fr           = WIRE_RIGHT[add_mod26(st1_letter_q, st1_rotor_q.right)];
    fm           = WIRE_MIDDLE[add_mod26(fr, st1_rotor_q.middle)];
    fl           = WIRE_LEFT[add_mod26(fm, st1_rotor_q.left)];
    rf           = WIRE_REFLECT[fl];
    bl           = sub_mod26(INV_LEFT[rf], st1_rotor_q.left);
    bm           = sub_mod26(INV_MIDDLE[bl], st1_rotor_q.middle);
    out_letter_d = sub_mod26(INV_RIGHT[bm], st1_rotor_q.right);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_right_q  <= RIGHT_RESET;
      start_middle_q <= 5'd0;
      start_left_q   <= 5'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_RIGHT:  start_right_q  <= cfg_data_i;
        CFG_START_MIDDLE: start_middle_q <= cfg_data_i;
        CFG_START_LEFT:   start_left_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotor_q <= '{left: 5'd0, middle: 5'd0, right: RIGHT_RESET};
      st1_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_accept) begin
        rotor_q <= rotor_d;
      end
      if (s_axis_tready) begin
        st1_v_q <= s_axis_tvalid;
      end
      if (out_rdy) begin
        out_v_q <= st1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      st1_letter_q <= add_mod26(s_axis_tdata[4:0], 5'd0);
      st1_rotor_q  <= rotor_d;
    end
    if (out_rdy && st1_v_q) begin
      out_letter_q <= out_letter_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_letter_q};

endmodule

/* hw/rtl/erc_checker.sv */
// ----------------------------------------------------------------------------
// Enigma cipher port checker
// Watches the top-level ports for stalls, result range and flow control.
// ----------------------------------------------------------------------------
`include "three_rotor_enigma_cipher_defines.svh"

module erc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled result
  `ERC_ASSERT(a_out_hold, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
              "stalled result changed")

  // Results are letters, upper pad bits zero
  `ERC_ASSERT(a_out_range, clk_i, rst_ni,
              m_axis_tvalid |-> (m_axis_tdata[7:5] == 3'b000) && (m_axis_tdata[4:0] < 5'd26),
              "result out of letter range")

  // A draining master side never stalls the input
  `ERC_ASSERT(a_no_stall, clk_i, rst_ni, m_axis_tready |-> s_axis_tready,
              "input stalled while output drains")

  // No result in the cycle after a reset edge
  `ERC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !m_axis_tvalid,
                     "result valid after reset")

endmodule

bind three_rotor_enigma_cipher erc_checker u_erc_checker (.*);
